// ===== design/aks_pkg.sv =====
// Shared constants, S-box and round constant tables and helper functions for the AES-128 key schedule.
package aks_pkg;

   localparam int WORD_COUNT = 44;
   localparam int ROUND_KEYS = 11;
   localparam int LAST_ROUND = 10;
   localparam int WORD_WIDTH = 32;
   localparam int ADDR_WIDTH = $clog2(WORD_COUNT);

   localparam logic [7:0] SBOX [256] = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
   };

   localparam logic [7:0] RCON [11] = '{
      8'h00,8'h01,8'h02,8'h04,8'h08,8'h10,8'h20,8'h40,8'h80,8'h1b,8'h36
   };

   function automatic logic [31:0] sub_rot(input logic [31:0] w);
      return {SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]], SBOX[w[31:24]]};
   endfunction

   // Transpose four column words into row-major bytes.
   function automatic logic [127:0] transpose(input logic [127:0] cols);
      logic [127:0] rows;
      rows = '0;
      for (int r = 0; r < 4; r++) begin
         for (int c = 0; c < 4; c++) begin
            rows[127 - 8*(4*r + c) -: 8] = cols[127 - 32*c - 8*r -: 8];
         end
      end
      return rows;
   endfunction

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_EXPAND = 4'b0010,
      ST_READ   = 4'b0100,
      ST_EMIT   = 4'b1000
   } state_type;

endpackage

// ===== design/aks_ram.sv =====
// Generic single-port-write, one-read RAM with registered read data.
module aks_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 44
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

// ===== design/aes128_key_expansion_core.sv =====
// Top level of the AES-128 key expansion core.
//
// Usage: present a cipher key on req_key_high/req_key_low with req_reverse_order
// and raise req_valid; the word is taken when req_stall is low, which it is only
// while the core is idle. The core then computes the 40 derived schedule words,
// one per cycle, in a four-word sliding window of registers, and writes every
// word into a 44-entry schedule RAM. After expansion, each round key is read
// from the RAM as four words (one per cycle, registered read) and presented as
// one rsp_ word, transposed to row order, with rsp_round_index, and rsp_last_round
// set on the eleventh round key. Forward mode gives round 0 first, reverse gives
// round 10 first.
// Steps: the RAM is filled with the four key words, then the 40 derived words;
// then each round key takes four reads of the single RAM read port, one step
// to collect the last read data, one to see the read drained and one to load
// the output. A new key is taken only after the last round key of the previous
// one is loaded into the output register.
// The rate is set by the single read port of the schedule RAM and by the serial
// word recurrence of the schedule.
// While rsp_stall is high the round key output holds; the next round key is read but waits to be loaded.
// Reset returns the core to idle with no output pending; RAM contents are left.
module aes128_key_expansion_core #(
   parameter int WORD_COUNT = aks_pkg::WORD_COUNT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [63:0] req_key_high,
   input  logic [63:0] req_key_low,
   input  logic        req_reverse_order,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [3:0]  rsp_round_index,
   output logic [63:0] rsp_round_high,
   output logic [63:0] rsp_round_low,
   output logic        rsp_last_round
);
   localparam int AW = $clog2(WORD_COUNT);

   aks_pkg::state_type state_ff, state_in;
   logic [127:0] win_ff, win_in;
   logic [AW-1:0] widx_ff, widx_in;
   logic          rev_ff, rev_in;
   logic [3:0]    rnd_ff, rnd_in;
   logic [3:0]    cnt_ff, cnt_in;
   logic [2:0]    col_ff, col_in;
   logic [127:0]  cols_ff, cols_in;
   logic          ov_ff, ov_in;
   logic [3:0]    oidx_ff, oidx_in;
   logic [127:0]  orow_ff, orow_in;
   logic          olast_ff, olast_in;

   logic          wr_en;
   logic [AW-1:0] wr_addr, rd_addr;
   logic [31:0]   wr_data, rd_data, t, nw;
   logic          rd_pend_ff, rd_pend_in;

   aks_ram #(.WIDTH(32), .DEPTH(WORD_COUNT)) u_ram (
      .clock(clock), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data),
      .rd_addr(rd_addr), .rd_data(rd_data)
   );

   // Next schedule word from the window (oldest word in top bits)
   always_comb begin
      t = win_ff[31:0];
      if (widx_ff[1:0] == 2'd0) begin
         t = aks_pkg::sub_rot(win_ff[31:0]) ^ {aks_pkg::RCON[widx_ff[AW-1:2]], 24'd0};
      end
      nw = win_ff[127:96] ^ t;
   end

   always_comb begin
      state_in   = state_ff;
      win_in     = win_ff;
      widx_in    = widx_ff;
      rev_in     = rev_ff;
      rnd_in     = rnd_ff;
      cnt_in     = cnt_ff;
      col_in     = col_ff;
      cols_in    = cols_ff;
      ov_in      = ov_ff;
      oidx_in    = oidx_ff;
      orow_in    = orow_ff;
      olast_in   = olast_ff;
      rd_pend_in = 1'b0;
      wr_en      = 1'b0;
      wr_addr    = widx_ff;
      wr_data    = nw;
      rd_addr    = AW'({rnd_ff, 2'b00}) + AW'(col_ff[1:0]);
      req_stall  = (state_ff != aks_pkg::ST_IDLE);

      // drop output word once taken
      if (ov_ff && !rsp_stall) begin
         ov_in = 1'b0;
      end

      unique case (state_ff)
         aks_pkg::ST_IDLE: begin
            if (req_valid) begin
               win_in  = {req_key_high, req_key_low};
               widx_in = AW'(4);
               rev_in  = req_reverse_order;
               state_in = aks_pkg::ST_EXPAND;
               cnt_in  = '0;
            end
            // write the key words first, one per cycle
         end
         aks_pkg::ST_EXPAND: begin
            wr_en = 1'b1;
            if (cnt_ff < 4'd4) begin
               wr_addr = AW'(cnt_ff);
               wr_data = win_ff[127 - 32*cnt_ff[1:0] -: 32];
               cnt_in  = cnt_ff + 4'd1;
            end else begin
               win_in  = {win_ff[95:0], nw};
               widx_in = widx_ff + AW'(1);
               if (widx_ff == AW'(WORD_COUNT - 1)) begin
                  state_in = aks_pkg::ST_READ;
                  cnt_in   = '0;
                  col_in   = '0;
                  rnd_in   = rev_ff ? 4'(aks_pkg::LAST_ROUND) : 4'd0;
               end
            end
         end
         aks_pkg::ST_READ: begin
            // issue four reads, collect registered data
            if (col_ff < 3'd4) begin
               rd_pend_in = 1'b1;
               col_in     = col_ff + 3'd1;
            end
            if (rd_pend_ff) begin
               cols_in = {cols_ff[95:0], rd_data};
            end
            if (col_ff == 3'd4 && !rd_pend_ff) begin
               state_in = aks_pkg::ST_EMIT;
            end
         end
         aks_pkg::ST_EMIT: begin
            if (!ov_ff || !rsp_stall) begin
               ov_in    = 1'b1;
               oidx_in  = rnd_ff;
               orow_in  = aks_pkg::transpose(cols_ff);
               olast_in = (cnt_ff == 4'(aks_pkg::ROUND_KEYS - 1));
               col_in   = '0;
               cnt_in   = cnt_ff + 4'd1;
               rnd_in   = rev_ff ? rnd_ff - 4'd1 : rnd_ff + 4'd1;
               state_in = (cnt_ff == 4'(aks_pkg::ROUND_KEYS - 1)) ?
                          aks_pkg::ST_IDLE : aks_pkg::ST_READ;
            end
         end
         default: state_in = aks_pkg::ST_IDLE;
      endcase
   end

   // Advance control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= aks_pkg::ST_IDLE;
         ov_ff      <= 1'b0;
         rd_pend_ff <= 1'b0;
         cnt_ff     <= '0;
         col_ff     <= '0;
      end else begin
         state_ff   <= state_in;
         ov_ff      <= ov_in;
         rd_pend_ff <= rd_pend_in;
         cnt_ff     <= cnt_in;
         col_ff     <= col_in;
      end
   end

   // Hold payload
   always_ff @(posedge clock) begin
      win_ff   <= win_in;
      widx_ff  <= widx_in;
      rev_ff   <= rev_in;
      rnd_ff   <= rnd_in;
      cols_ff  <= cols_in;
      oidx_ff  <= oidx_in;
      orow_ff  <= orow_in;
      olast_ff <= olast_in;
   end

   assign rsp_valid       = ov_ff;
   assign rsp_round_index = oidx_ff;
   assign rsp_round_high  = orow_ff[127:64];
   assign rsp_round_low   = orow_ff[63:0];
   assign rsp_last_round  = olast_ff;
endmodule

// ===== design/aks_checker.sv =====
// Port-level checker for the key expansion core, bound to the top level.
module aks_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [3:0]  rsp_round_index,
   input logic [63:0] rsp_round_high,
   input logic        rsp_last_round
);
   // Round index stays in range
   a_index: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_round_index <= 4'd10)
      else $error("round index out of range");

   // Stalled word holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_round_high))
      else $error("stalled word changed");

   // Last round is round 0 or 10
   a_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last_round |-> rsp_round_index == 4'd0 || rsp_round_index == 4'd10)
      else $error("bad last round index");

   // A taken key makes the core busy on the next cycle
   a_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("core not busy after taking a key");
endmodule

bind aes128_key_expansion_core aks_checker u_aks_checker (.*);

// ===== tb/sv/tb.sv =====
// Testbench for the AES-128 key expansion core: round keys checked against a local key schedule.
module tb;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [63:0] req_key_high = '0;
   logic [63:0] req_key_low = '0;
   logic        req_reverse_order = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [3:0]  rsp_round_index;
   logic [63:0] rsp_round_high;
   logic [63:0] rsp_round_low;
   logic        rsp_last_round;

   typedef struct packed {
      logic [3:0]  index;
      logic [63:0] high;
      logic [63:0] low;
      logic        last;
   } round_key_type;

   round_key_type round_key_q[$];
   int          error_count = 0;
   int          cycle_count = 0;
   int          stall_left = 0;
   bit          calm = 1'b0;

   localparam int CYCLE_LIMIT = 400000;

   aes128_key_expansion_core dut (.*);

   always #1 clock = ~clock;

   // Look up one S-box byte
   function automatic logic [7:0] sbox_byte(input logic [7:0] b);
      return aks_pkg::SBOX[b];
   endfunction

   // Expand a key and queue the eleven transposed round keys in emit order
   task automatic predict_round_keys(input logic [63:0] kh, input logic [63:0] kl,
                                     input logic rev);
      logic [31:0] w [44];
      logic [31:0] t;
      logic [7:0]  rc;
      logic [127:0] rows;
      round_key_type rk;
      int          rnd;
      w[0] = kh[63:32]; w[1] = kh[31:0]; w[2] = kl[63:32]; w[3] = kl[31:0];
      rc = 8'h01;
      for (int i = 4; i < 44; i++) begin
         t = w[i-1];
         if (i % 4 == 0) begin
            t = {sbox_byte(t[23:16]) ^ rc, sbox_byte(t[15:8]), sbox_byte(t[7:0]),
                 sbox_byte(t[31:24])};
            rc = rc[7] ? ((rc << 1) ^ 8'h1b) : (rc << 1);
         end
         w[i] = w[i-4] ^ t;
      end
      for (int k = 0; k < 11; k++) begin
         rnd = rev ? 10 - k : k;
         for (int r = 0; r < 4; r++)
            for (int c = 0; c < 4; c++)
               rows[127 - 8*(4*r + c) -: 8] = w[4*rnd + c][31 - 8*r -: 8];
         rk.index = rnd[3:0];
         rk.high = rows[127:64];
         rk.low = rows[63:0];
         rk.last = (k == 10);
         round_key_q.push_back(rk);
      end
   endtask

   // Random idle burst, none once calm; drop valid while idle
   task automatic idle_gap();
      if (!calm && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 18)) @(posedge clock);
      end
   endtask

   // Send one key word and wait for acceptance; valid stays up for the next word
   task automatic send_key(input logic [63:0] kh, input logic [63:0] kl, input logic rev);
      idle_gap();
      req_valid <= 1'b1;
      req_key_high <= kh;
      req_key_low <= kl;
      req_reverse_order <= rev;
      do @(posedge clock); while (req_stall);
      predict_round_keys(kh, kl, rev);
   endtask

   // Drop valid and wait until every expected round key has come
   task automatic drain();
      req_valid <= 1'b0;
      while (round_key_q.size() != 0) @(posedge clock);
   endtask

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   // Directed: extreme keys, both directions, the standard test key
   task automatic test_directed();
      send_key('0, '0, 1'b0);
      send_key('0, '0, 1'b1);
      send_key('1, '1, 1'b0);
      send_key('1, '1, 1'b1);
      send_key(64'h2b7e151628aed2a6, 64'habf7158809cf4f3c, 1'b0);
      send_key(64'h2b7e151628aed2a6, 64'habf7158809cf4f3c, 1'b1);
      send_key(64'haaaaaaaaaaaaaaaa, 64'h5555555555555555, 1'b0);
      send_key(64'h5555555555555555, 64'haaaaaaaaaaaaaaaa, 1'b1);
      send_key(64'h8000000000000000, 64'h0000000000000001, 1'b0);
   endtask

   // Hold off until every round key has come, then resume
   task automatic test_drain_pause();
      send_key(rand64(), rand64(), 1'($urandom));
      drain();
      send_key(rand64(), rand64(), 1'($urandom));
   endtask

   task automatic test_random(input int n);
      for (int i = 0; i < n; i++)
         send_key(rand64(), rand64(), 1'($urandom));
   endtask

   // Random receiver stall bursts, none once calm
   always @(posedge clock) begin
      if (calm || reset) begin
         rsp_stall <= 1'b0;
         stall_left = 0;
      end else if (stall_left > 0) begin
         stall_left--;
         if (stall_left == 0)
            rsp_stall <= 1'b0;
      end else if ($urandom_range(0, 7) == 0) begin
         rsp_stall <= 1'b1;
         stall_left = $urandom_range(1, 18);
      end
   end

   // Compare each accepted round key word with the oldest expectation
   always @(posedge clock) begin
      round_key_type exp_rk;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (round_key_q.size() == 0) begin
            $display("%0t: unexpected round key idx=%0d", $time, rsp_round_index);
            error_count++;
         end else begin
            exp_rk = round_key_q.pop_front();
            if (rsp_round_index !== exp_rk.index) begin
               $display("%0t: round_index exp %0d got %0d", $time, exp_rk.index,
                        rsp_round_index);
               error_count++;
            end
            if (rsp_round_high !== exp_rk.high) begin
               $display("%0t: round_high exp %h got %h", $time, exp_rk.high, rsp_round_high);
               error_count++;
            end
            if (rsp_round_low !== exp_rk.low) begin
               $display("%0t: round_low exp %h got %h", $time, exp_rk.low, rsp_round_low);
               error_count++;
            end
            if (rsp_last_round !== exp_rk.last) begin
               $display("%0t: last_round exp %0b got %0b", $time, exp_rk.last,
                        rsp_last_round);
               error_count++;
            end
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_drain_pause();
      test_random(140);
      calm = 1'b1;
      test_random(20);
      drain();
      repeat (120) @(posedge clock);
      if (error_count == 0 && round_key_q.size() == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end
endmodule
